/* rtl/ttmu_pkg.sv */
package ttmu_pkg;

  localparam int TABLE_SLOTS       = 16;
  localparam int MAX_TABLE_ENTRIES = 8192;
  localparam int SLOT_W            = $clog2(TABLE_SLOTS);
  localparam int IDX_W             = $clog2(MAX_TABLE_ENTRIES);
  localparam int ADDR_W            = SLOT_W + IDX_W;
  localparam int SLOT_SHIFT        = 16;
  localparam int DESC_W            = 64;
  localparam int VA_W              = 32;
  localparam int PA_W              = 40;
  localparam int CNT_W             = 21;
  localparam int LOW_ATTR_BITS     = 12;

  typedef logic [1:0] level_t;
  localparam level_t LAST_LEVEL = 2'd3;

  typedef enum logic [1:0] {
    GRAN_4K  = 2'd0,
    GRAN_16K = 2'd1,
    GRAN_64K = 2'd2
  } granule_e;

  typedef enum logic [0:0] {
    CMD_MAP   = 1'b0,
    CMD_UNMAP = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_OVERLAP  = 3'd2,
    ST_MISSING  = 3'd3,
    ST_NO_TABLE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLR_TOP,
    S_IDLE,
    S_WALK,
    S_CHK,
    S_CLR_CHILD,
    S_FREE_RD,
    S_FREE_CHK,
    S_UP,
    S_UP_CHK,
    S_EMP_RD,
    S_EMP_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [0:0]      command;
    logic [VA_W-1:0] virt_addr;
    logic [PA_W-1:0] phys_addr;
    logic [VA_W-1:0] region_size;
  } ttmu_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [CNT_W-1:0] leaves_done;
  } ttmu_out_t;

  typedef struct packed {
    logic [4:0] lsb;
    logic [3:0] bits;
  } lev_geo_t;

  // lowest address bit and index width of a level
  function automatic lev_geo_t lev_geo(input logic [1:0] mode, input level_t lv);
    lev_geo_t g;
    g = '{lsb: 5'd12, bits: 4'd9};
    case (mode)
      GRAN_16K: begin
        case (lv)
          2'd2:    g = '{lsb: 5'd25, bits: 4'd7};
          default: g = '{lsb: 5'd14, bits: 4'd11};
        endcase
      end
      GRAN_64K: begin
        case (lv)
          2'd2:    g = '{lsb: 5'd29, bits: 4'd3};
          default: g = '{lsb: 5'd16, bits: 4'd13};
        endcase
      end
      default: begin
        case (lv)
          2'd1:    g = '{lsb: 5'd30, bits: 4'd2};
          2'd2:    g = '{lsb: 5'd21, bits: 4'd9};
          default: g = '{lsb: 5'd12, bits: 4'd9};
        endcase
      end
    endcase
    return g;
  endfunction

  function automatic level_t root_level(input logic [1:0] mode);
    level_t lv;
    case (mode)
      GRAN_16K, GRAN_64K: lv = 2'd2;
      default:            lv = 2'd1;
    endcase
    return lv;
  endfunction

  function automatic logic [IDX_W-1:0] idx_mask(input logic [3:0] bits);
    logic [31:0] m;
    m = (32'd1 << bits) - 32'd1;
    return m[IDX_W-1:0];
  endfunction

endpackage

/* rtl/ttmu_desc_store.sv */
module ttmu_desc_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ttmu_pkg::ADDR_W-1:0] waddr_i,
  input  logic [ttmu_pkg::DESC_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ttmu_pkg::ADDR_W-1:0] raddr_i,
  output logic [ttmu_pkg::DESC_W-1:0] rdata_o
);
  import ttmu_pkg::*;

  logic [DESC_W-1:0] mem [TABLE_SLOTS*MAX_TABLE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/translation_table_map_unmap_top.sv */
// Translation table keeper for a 32-bit virtual space with a 4, 16 or 64 KB
// granule. Each transaction is one map or unmap command and returns one
// status and a count of leaf descriptors handled. Commands run one at a time
// on a sequencer around a descriptor memory with one read and one write port:
// a walk step reads and then checks one descriptor per level, each table
// allocation clears 2^(index bits) entries at one per cycle, freeing a 4 KB
// level-2 subtree and each emptiness check after an unmap read and check the
// child entries in turn; a bad size goes straight to the result. After reset
// and every granule write the 4, 128 or 8 entry top table (4, 16, 64 KB) is
// cleared before a command is taken; a granule write drops the whole mapping.
module translation_table_map_unmap_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ttmu_pkg::ttmu_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ttmu_pkg::ttmu_out_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_data_i
);
  import ttmu_pkg::*;

  state_e                 state_q, state_d;
  logic [1:0]             granule_q, granule_d;
  logic [TABLE_SLOTS-1:0] used_q, used_d;
  logic [0:0]             cmd_q, cmd_d;
  logic [VA_W-1:0]        va_q, va_d, sz_q, sz_d;
  logic [PA_W-1:0]        pa_q, pa_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  level_t                 lv_q, lv_d;
  logic [SLOT_W-1:0]      slot_q, slot_d, child_q, child_d;
  logic [SLOT_W-1:0]      path_slot_q [2];
  logic [SLOT_W-1:0]      path_slot_d [2];
  logic [IDX_W-1:0]       path_idx_q [2];
  logic [IDX_W-1:0]       path_idx_d [2];
  logic [IDX_W-1:0]       ecnt_q, ecnt_d;
  status_e                status_q, status_d;
  logic                   out_valid_q, out_valid_d;
  ttmu_out_t              out_data_q, out_data_d;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DESC_W-1:0] mem_wdata, rdata;

  lev_geo_t          geo, geo_last, geo_root;
  logic [VA_W-1:0]   va_sh, lsb_mask, blk;
  logic [IDX_W-1:0]  cur_idx, child_last, top_last;
  logic              brk, d_valid, d_table;
  logic [SLOT_W-1:0] d_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  level_t            lv_start, lvm1;
  logic              bad_size, out_free, sz_zero_next;
  logic [VA_W-1:0]   page_mask, sz_next;
  logic [DESC_W-1:0] leaf_desc, table_desc;

  ttmu_desc_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign geo        = lev_geo(granule_q, lv_q);
  assign geo_last   = lev_geo(granule_q, LAST_LEVEL);
  assign geo_root   = lev_geo(granule_q, lv_start);
  assign va_sh      = va_q >> geo.lsb;
  assign cur_idx    = va_sh[IDX_W-1:0] & idx_mask(geo.bits);
  assign lsb_mask   = (32'd1 << geo.lsb) - 32'd1;
  assign blk        = 32'd1 << geo.lsb;
  assign brk        = (lv_q == LAST_LEVEL) || (((va_q & lsb_mask) == '0) && (sz_q >= blk));
  assign child_last = idx_mask(geo_last.bits);
  assign top_last   = idx_mask(geo_root.bits);
  assign lv_start   = root_level(granule_q);
  assign lvm1       = lv_q - 2'd1;
  assign sz_next    = sz_q - blk;
  assign sz_zero_next = (sz_next == '0);

  assign d_valid = rdata[0];
  assign d_table = rdata[0] & rdata[1];
  assign d_slot  = rdata[SLOT_SHIFT +: SLOT_W];

  assign page_mask = (32'd1 << geo_last.lsb) - 32'd1;
  assign bad_size  = (in_data_i.region_size == '0) ||
                     ((in_data_i.region_size & page_mask) != '0);

  assign leaf_desc = {9'd0, 1'b1, 1'b1, 13'd0, pa_q[PA_W-1:LOW_ATTR_BITS], 1'b0, 1'b1,
                      3'd0, 1'b1, 4'd0, (lv_q == LAST_LEVEL), 1'b1};
  assign table_desc = DESC_W'({free_slot, 16'h0003});

  assign out_free = !out_valid_q || !out_stall_i;

  // lowest free slot above the top table
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = TABLE_SLOTS - 1; s >= 1; s--) begin
      if (!used_q[s]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(s);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR_TOP: if (ecnt_q == top_last) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) state_d = bad_size ? S_DONE : S_WALK;
      end
      S_WALK: state_d = S_CHK;
      S_CHK: begin
        if (cmd_q == CMD_MAP) begin
          if (brk) begin
            state_d = (d_valid || sz_zero_next) ? S_DONE : S_WALK;
          end else if (d_table && lv_q != LAST_LEVEL) begin
            state_d = S_WALK;
          end else begin
            state_d = free_found ? S_CLR_CHILD : S_DONE;
          end
        end else begin
          if (brk) begin
            if (!d_valid) state_d = S_DONE;
            else if (d_table && lv_q == 2'd1 && d_slot != '0) state_d = S_FREE_RD;
            else state_d = S_UP;
          end else begin
            state_d = d_table ? S_WALK : S_DONE;
          end
        end
      end
      S_CLR_CHILD: if (ecnt_q == child_last) state_d = S_WALK;
      S_FREE_RD:   state_d = S_FREE_CHK;
      S_FREE_CHK:  state_d = (ecnt_q == child_last) ? S_UP : S_FREE_RD;
      S_UP: begin
        if (lv_q > lv_start) state_d = S_UP_CHK;
        else state_d = (sz_q == '0) ? S_DONE : S_WALK;
      end
      S_UP_CHK: begin
        if (d_slot == '0 || !d_table) state_d = (sz_q == '0) ? S_DONE : S_WALK;
        else state_d = S_EMP_RD;
      end
      S_EMP_RD: state_d = S_EMP_CHK;
      S_EMP_CHK: begin
        if (d_valid) state_d = (sz_q == '0) ? S_DONE : S_WALK;
        else if (ecnt_q == child_last) state_d = S_UP;
        else state_d = S_EMP_RD;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) state_d = S_CLR_TOP;
  end

  // datapath and memory control
  always_comb begin
    granule_d   = granule_q;
    used_d      = used_q;
    cmd_d       = cmd_q;
    va_d        = va_q;
    pa_d        = pa_q;
    sz_d        = sz_q;
    cnt_d       = cnt_q;
    lv_d        = lv_q;
    slot_d      = slot_q;
    child_d     = child_q;
    path_slot_d = path_slot_q;
    path_idx_d  = path_idx_q;
    ecnt_d      = ecnt_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = {slot_q, cur_idx};
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = {slot_q, cur_idx};

    unique case (state_q)
      S_CLR_TOP: begin
        mem_we    = 1'b1;
        mem_waddr = {{SLOT_W{1'b0}}, ecnt_q};
        ecnt_d    = ecnt_q + 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = in_data_i.command;
          va_d     = in_data_i.virt_addr;
          pa_d     = in_data_i.phys_addr;
          sz_d     = in_data_i.region_size;
          cnt_d    = '0;
          lv_d     = lv_start;
          slot_d   = '0;
          status_d = bad_size ? ST_BAD_SIZE : ST_OK;
        end
      end
      S_WALK: begin
        mem_re = 1'b1;
        if (lv_q != LAST_LEVEL) begin
          path_slot_d[lv_q[1]] = slot_q;
          path_idx_d[lv_q[1]]  = cur_idx;
        end
      end
      S_CHK: begin
        if (cmd_q == CMD_MAP) begin
          if (brk) begin
            if (d_valid) begin
              status_d = ST_OVERLAP;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = leaf_desc;
              cnt_d     = cnt_q + 1'b1;
              va_d      = va_q + blk;
              pa_d      = pa_q + PA_W'(blk);
              sz_d      = sz_next;
              lv_d      = lv_start;
              slot_d    = '0;
              status_d  = ST_OK;
            end
          end else if (d_table && lv_q != LAST_LEVEL) begin
            slot_d = d_slot;
            lv_d   = lv_q + 2'd1;
          end else if (!free_found) begin
            status_d = ST_NO_TABLE;
          end else begin
            used_d[free_slot] = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = table_desc;
            slot_d    = free_slot;
            lv_d      = lv_q + 2'd1;
            ecnt_d    = '0;
          end
        end else begin
          if (brk) begin
            if (!d_valid) begin
              status_d = ST_MISSING;
            end else begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
              va_d   = va_q + blk;
              sz_d   = sz_next;
              child_d = d_slot;
              ecnt_d  = '0;
              if (d_table && lv_q == 2'd2 && d_slot != '0) used_d[d_slot] = 1'b0;
            end
          end else if (!d_table) begin
            status_d = ST_MISSING;
          end else begin
            slot_d = d_slot;
            lv_d   = lv_q + 2'd1;
          end
        end
      end
      S_CLR_CHILD: begin
        mem_we    = 1'b1;
        mem_waddr = {slot_q, ecnt_q};
        ecnt_d    = ecnt_q + 1'b1;
      end
      S_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {child_q, ecnt_q};
      end
      S_FREE_CHK: begin
        if (d_table && d_slot != '0) used_d[d_slot] = 1'b0;
        if (ecnt_q == child_last) used_d[child_q] = 1'b0;
        else ecnt_d = ecnt_q + 1'b1;
      end
      S_UP: begin
        if (lv_q > lv_start) begin
          lv_d      = lvm1;
          mem_re    = 1'b1;
          mem_raddr = {path_slot_q[lvm1[1]], path_idx_q[lvm1[1]]};
        end else begin
          lv_d     = lv_start;
          slot_d   = '0;
          status_d = ST_OK;
        end
      end
      S_UP_CHK: begin
        if (d_slot == '0 || !d_table) begin
          lv_d     = lv_start;
          slot_d   = '0;
          status_d = ST_OK;
        end else begin
          child_d = d_slot;
          ecnt_d  = '0;
        end
      end
      S_EMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {child_q, ecnt_q};
      end
      S_EMP_CHK: begin
        if (d_valid) begin
          lv_d     = lv_start;
          slot_d   = '0;
          status_d = ST_OK;
        end else if (ecnt_q == child_last) begin
          mem_we    = 1'b1;
          mem_waddr = {path_slot_q[lv_q[1]], path_idx_q[lv_q[1]]};
          used_d[child_q] = 1'b0;
        end else begin
          ecnt_d = ecnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{status: status_q, leaves_done: cnt_q};
        end
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      granule_d = cfg_data_i;
      used_d    = TABLE_SLOTS'(1);
      ecnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR_TOP;
      granule_q   <= GRAN_4K;
      used_q      <= TABLE_SLOTS'(1);
      ecnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      granule_q   <= granule_d;
      used_q      <= used_d;
      ecnt_q      <= ecnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    va_q        <= va_d;
    pa_q        <= pa_d;
    sz_q        <= sz_d;
    cnt_q       <= cnt_d;
    lv_q        <= lv_d;
    slot_q      <= slot_d;
    child_q     <= child_d;
    path_slot_q <= path_slot_d;
    path_idx_q  <= path_idx_d;
    status_q    <= status_d;
    out_data_q  <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* tb/ttmu_checker.sv */
module ttmu_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ttmu_pkg::ttmu_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ttmu_pkg::ttmu_out_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_data_i,
  output int                  pending_o,
  output int                  errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttmu_pkg::*;

  localparam bit [63:0] D_VALID = 64'h1;
  localparam bit [63:0] D_TYPE  = 64'h2;
  localparam bit [63:0] D_EL0   = 64'h40;
  localparam bit [63:0] D_AF    = 64'h400;
  localparam bit [63:0] D_PXN   = 64'd1 << 53;
  localparam bit [63:0] D_XN    = 64'd1 << 54;
  localparam int        LEAF_LV = 3;

  bit [63:0] desc_mem [TABLE_SLOTS*MAX_TABLE_ENTRIES];
  bit        slot_busy [TABLE_SLOTS];
  int        pg_bits, lvl_bits, top_lv, top_bits;
  ttmu_out_t status_q [$];
  int        errors = 0;

  assign pending_o = status_q.size();
  assign errors_o  = errors;

  function automatic int lsb_of(int lv);
    return pg_bits + (LEAF_LV - lv) * lvl_bits;
  endfunction

  function automatic int bits_of(int lv);
    return (lv == top_lv) ? top_bits : lvl_bits;
  endfunction

  function automatic int idx_of(int lv, bit [31:0] va);
    return int'((va >> lsb_of(lv)) & ((32'd1 << bits_of(lv)) - 32'd1));
  endfunction

  function automatic int loc(int s, int i);
    return (s % TABLE_SLOTS) * MAX_TABLE_ENTRIES + (i & (MAX_TABLE_ENTRIES - 1));
  endfunction

  function automatic bit is_tbl(bit [63:0] d, int lv);
    return lv < LEAF_LV && d[0] && d[1];
  endfunction

  function automatic int slot_in(bit [63:0] d);
    return int'(d[23:16]) % TABLE_SLOTS;
  endfunction

  function automatic bit fits(bit [31:0] va, bit [31:0] sz, int lsb);
    return ((va & ((32'd1 << lsb) - 32'd1)) == 0) && ({32'd0, sz} >= (64'd1 << lsb));
  endfunction

  function automatic void clear_slot(int s);
    for (int i = 0; i < MAX_TABLE_ENTRIES; i++) desc_mem[loc(s, i)] = '0;
  endfunction

  function automatic int grab_slot();
    for (int s = 1; s < TABLE_SLOTS; s++) begin
      if (!slot_busy[s]) begin
        slot_busy[s] = 1'b1;
        clear_slot(s);
        return s;
      end
    end
    return -1;
  endfunction

  function automatic void release_tree(int s, int lv);
    bit [63:0] d;
    if (s == 0 || lv > LEAF_LV) return;
    for (int i = 0; i < (1 << bits_of(lv)); i++) begin
      d = desc_mem[loc(s, i)];
      if (is_tbl(d, lv)) release_tree(slot_in(d), lv + 1);
    end
    slot_busy[s] = 1'b0;
  endfunction

  function automatic void set_granule(logic [1:0] m);
    case (m)
      GRAN_16K: begin pg_bits = 14; lvl_bits = 11; top_lv = 2; top_bits = 7; end
      GRAN_64K: begin pg_bits = 16; lvl_bits = 13; top_lv = 2; top_bits = 3; end
      default:  begin pg_bits = 12; lvl_bits = 9;  top_lv = 1; top_bits = 2; end
    endcase
    for (int s = 0; s < TABLE_SLOTS; s++) slot_busy[s] = (s == 0);
    clear_slot(0);
  endfunction

  function automatic status_e map_region(bit [31:0] va, bit [39:0] pa, bit [31:0] sz,
                                         ref int cnt);
    int lv, s, n, a;
    bit [31:0] blk;
    do begin
      lv = top_lv;
      s = 0;
      while (lv < LEAF_LV) begin
        a = loc(s, idx_of(lv, va));
        if (fits(va, sz, lsb_of(lv))) break;
        if (is_tbl(desc_mem[a], lv)) s = slot_in(desc_mem[a]);
        else begin
          n = grab_slot();
          if (n < 0) return ST_NO_TABLE;
          desc_mem[a] = (64'(n) << SLOT_SHIFT) | D_VALID | D_TYPE;
          s = n;
        end
        lv++;
      end
      a = loc(s, idx_of(lv, va));
      if (desc_mem[a][0]) return ST_OVERLAP;
      desc_mem[a] = {24'd0, pa & ~40'hFFF} | D_VALID | ((lv == LEAF_LV) ? D_TYPE : 64'd0)
                    | D_PXN | D_XN | D_EL0 | D_AF;
      cnt++;
      blk = 32'd1 << lsb_of(lv);
      va += blk;
      pa += 40'(blk);
      sz -= blk;
    end while (sz > 0);
    return ST_OK;
  endfunction

  function automatic status_e unmap_region(bit [31:0] va, bit [31:0] sz, ref int cnt);
    int lv, s, ix, a, b, child;
    int path_s [4];
    int path_i [4];
    bit [63:0] d;
    bit empty;
    bit [31:0] blk;
    do begin
      lv = top_lv;
      s = 0;
      while (lv < LEAF_LV) begin
        ix = idx_of(lv, va);
        d = desc_mem[loc(s, ix)];
        path_s[lv] = s;
        path_i[lv] = ix;
        if (fits(va, sz, lsb_of(lv))) break;
        if (!is_tbl(d, lv)) return ST_MISSING;
        s = slot_in(d);
        lv++;
      end
      a = loc(s, idx_of(lv, va));
      if (!desc_mem[a][0]) return ST_MISSING;
      if (is_tbl(desc_mem[a], lv)) release_tree(slot_in(desc_mem[a]), lv + 1);
      desc_mem[a] = '0;
      cnt++;
      b = lv;
      while (b > top_lv) begin
        b--;
        a = loc(path_s[b], path_i[b]);
        child = slot_in(desc_mem[a]);
        empty = 1'b1;
        if (child == 0 || !is_tbl(desc_mem[a], b)) break;
        for (int i = 0; i < (1 << bits_of(b + 1)); i++) begin
          if (desc_mem[loc(child, i)][0]) begin
            empty = 1'b0;
            break;
          end
        end
        if (!empty) break;
        desc_mem[a] = '0;
        slot_busy[child] = 1'b0;
      end
      blk = 32'd1 << lsb_of(lv);
      va += blk;
      sz -= blk;
    end while (sz > 0);
    return ST_OK;
  endfunction

  function automatic ttmu_out_t predict_status(ttmu_in_t it);
    ttmu_out_t r;
    int cnt;
    status_e st;
    cnt = 0;
    if (it.region_size == 0 || (it.region_size & ((32'd1 << pg_bits) - 32'd1)) != 0)
      st = ST_BAD_SIZE;
    else if (it.command == CMD_MAP)
      st = map_region(it.virt_addr, it.phys_addr, it.region_size, cnt);
    else
      st = unmap_region(it.virt_addr, it.region_size, cnt);
    r.status = st;
    r.leaves_done = cnt[CNT_W-1:0];
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial set_granule(GRAN_4K);

  always @(posedge clk_i) begin
    ttmu_out_t e;
    if (rst_ni) begin
      if (cfg_we_i) set_granule(cfg_data_i);
      if (in_valid_i && !in_stall_i) status_q.push_back(predict_status(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) report("unexpected transaction", 1, 0);
        else begin
          e = status_q.pop_front();
          if (out_data_i.status !== e.status)
            report("status", out_data_i.status, e.status);
          if (out_data_i.leaves_done !== e.leaves_done)
            report("leaves_done", out_data_i.leaves_done, e.leaves_done);
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ttmu_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    bit [31:0] va;
    bit [31:0] sz;
  } region_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  ttmu_in_t  in_data = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  ttmu_out_t out_data_o;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_data = '0;
  int        pending, errors;
  int        idle_cycles = 0;
  bit        long_hold = 1'b0;
  int        burst_left = 0;
  logic [1:0] mode = GRAN_4K;
  region_t   mapped_q [$];

  translation_table_map_unmap_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  ttmu_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_i (out_data_o),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int pct, left;
    pct = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 50;
            default: pct = 90;
          endcase
          left = $urandom_range(16, 96);
        end
        left--;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("translation_table_map_unmap_top verification failed");
      $finish;
    end
  end

  task automatic send(input logic [0:0] cmd, input bit [31:0] va, input bit [39:0] pa,
                      input bit [31:0] sz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_data <= '{command: cmd, virt_addr: va, phys_addr: pa, region_size: sz};
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain();
    cfg_data <= m;
    cfg_we <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    mode = m;
    mapped_q.delete();
  endtask

  function automatic bit [39:0] rand_pa();
    return 40'({$urandom, $urandom});
  endfunction

  task automatic random_item();
    int pg, bpl, r, k;
    bit [31:0] va, sz;
    region_t rgn;
    pg = (mode == GRAN_16K) ? 14 : (mode == GRAN_64K) ? 16 : 12;
    bpl = (mode == GRAN_16K) ? 11 : (mode == GRAN_64K) ? 13 : 9;
    r = $urandom_range(0, 99);
    if (r < 45 && mapped_q.size() < 6) begin
      va = $urandom & ~((32'd1 << pg) - 32'd1);
      if ($urandom_range(0, 9) == 0) begin
        if (mode == GRAN_16K || mode == GRAN_64K) begin
          va &= ~((32'd1 << (pg + bpl)) - 32'd1);
          sz = 32'd1 << (pg + bpl);
        end else begin
          va &= 32'hC000_0000;
          sz = 32'(($urandom_range(1, 2))) << 30;
        end
      end else begin
        sz = 32'($urandom_range(1, 4)) << pg;
      end
      rgn.va = va;
      rgn.sz = sz;
      mapped_q.push_back(rgn);
      send(CMD_MAP, va, rand_pa(), sz);
    end else if (r < 85 && mapped_q.size() != 0) begin
      k = $urandom_range(0, mapped_q.size() - 1);
      rgn = mapped_q[k];
      mapped_q.delete(k);
      send(CMD_UNMAP, rgn.va, rand_pa(), rgn.sz);
    end else if (r < 93) begin
      send(1'($urandom_range(0, 1)), $urandom, rand_pa(), $urandom | 32'd1);
    end else begin
      send(CMD_UNMAP, $urandom & ~((32'd1 << pg) - 32'd1), rand_pa(), 32'd1 << pg);
    end
  endtask

  initial begin
    int counts [5];
    logic [1:0] modes [5];
    counts = '{180, 90, 40, 60, 90};
    modes = '{GRAN_4K, GRAN_16K, GRAN_64K, 2'd3, GRAN_4K};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_MAP, 32'h0000_1000, 40'h12_3456_7000, 32'd0);
    send(CMD_UNMAP, 32'h0000_1000, 40'd0, 32'h0000_0800);
    send(CMD_MAP, 32'h0000_1000, 40'hFF_FFFF_FFFF, 32'h0000_1000);
    send(CMD_MAP, 32'h0000_1000, 40'h00_0000_0000, 32'h0000_1000);
    send(CMD_UNMAP, 32'h0000_1000, 40'd0, 32'h0000_1000);
    send(CMD_UNMAP, 32'h0000_1000, 40'd0, 32'h0000_1000);
    send(CMD_MAP, 32'h4000_0000, 40'h80_4000_0000, 32'h4000_0000);
    send(CMD_MAP, 32'h0020_0000, 40'h00_0020_0000, 32'h0020_0000);
    send(CMD_MAP, 32'h0020_1000, 40'h00_0990_1000, 32'h0000_1000);
    send(CMD_UNMAP, 32'h0020_0000, 40'd0, 32'h0020_0000);
    send(CMD_MAP, 32'hFFFF_F000, 40'hFF_FFFF_F000, 32'h0000_2000);
    send(CMD_UNMAP, 32'hFFFF_F000, 40'd0, 32'h0000_2000);
    send(CMD_MAP, 32'h0000_0000, 40'hFF_FFFF_FFFF, 32'hC000_0000);
    send(CMD_UNMAP, 32'h4000_0000, 40'd0, 32'h4000_0000);
    drain();
    // exhaust the table pool
    for (int k = 0; k < 16; k++)
      send(CMD_MAP, 32'h8000_0000 + 32'(k) * 32'h0020_0000, rand_pa(), 32'h0000_1000);

    for (int p = 0; p < 5; p++) begin
      set_mode(modes[p]);
      for (int n = 0; n < counts[p]; n++) begin
        if (p == 0 && n == 20) long_hold = 1'b1;
        random_item();
      end
    end
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0)
      $display("translation_table_map_unmap_top verification clean");
    else
      $display("translation_table_map_unmap_top verification failed");
    $finish;
  end

endmodule
